// ===== rtl/cid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cid_pkg
// Types, opcodes and bit-interleave helpers for the dyadic cell-id unit.
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int          WORD_BITS = 64;
  localparam int          POS_BITS  = 32;
  localparam int          AXES      = 4;
  localparam logic [2:0]  DIM_RESET = 3'd2;

  typedef enum logic [2:0] {
    OP_RANK       = 3'd0,
    OP_SPLIT      = 3'd1,
    OP_BUILD      = 3'd2,
    OP_AXIS_SHIFT = 3'd3,
    OP_SHIFT_ALL  = 3'd4,
    OP_ADD_IDS    = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] cell_a;
    logic [63:0] cell_b;
    logic [5:0]  level;
    logic [1:0]  axis_sel;
    logic [31:0] coord0;
    logic [31:0] coord1;
    logic [31:0] coord2;
    logic [31:0] coord3;
  } cid_in_t;

  typedef struct packed {
    logic [63:0] cell_out;
    logic [5:0]  rank_out;
    logic [31:0] pos0;
    logic [31:0] pos1;
    logic [31:0] pos2;
    logic [31:0] pos3;
    logic        rank_error;
  } cid_out_t;

  // Per-axis bit masks below the rank and the position of each axis' lowest bit.
  typedef struct packed {
    logic [AXES-1:0][WORD_BITS-1:0] mask;
    logic [AXES-1:0][1:0]           off;
  } axis_map_t;

  // Position of the leading one; 0 for a zero word.
  function automatic logic [5:0] lead_one(input logic [WORD_BITS-1:0] x);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (x[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  // Spread bit k of v to bit k*d.
  function automatic logic [WORD_BITS-1:0] dilate(input logic [WORD_BITS-1:0] v,
                                                  input logic [2:0] d);
    logic [WORD_BITS-1:0] r;
    r = '0;
    case (d)
      3'd2: begin
        for (int k = 0; k < 32; k++) r[2*k] = v[k];
      end
      3'd3: begin
        for (int k = 0; k < 22; k++) r[3*k] = v[k];
      end
      3'd4: begin
        for (int k = 0; k < 16; k++) r[4*k] = v[k];
      end
      default: begin
        r = v;
      end
    endcase
    return r;
  endfunction

  // Gather bit k*d of x into bit k.
  function automatic logic [WORD_BITS-1:0] compact(input logic [WORD_BITS-1:0] x,
                                                   input logic [2:0] d);
    logic [WORD_BITS-1:0] r;
    r = '0;
    case (d)
      3'd2: begin
        for (int k = 0; k < 32; k++) r[k] = x[2*k];
      end
      3'd3: begin
        for (int k = 0; k < 22; k++) r[k] = x[3*k];
      end
      3'd4: begin
        for (int k = 0; k < 16; k++) r[k] = x[4*k];
      end
      default: begin
        r = x;
      end
    endcase
    return r;
  endfunction

  // Residue mod 3 of a 6-bit value by folding base-4 digits.
  function automatic logic [1:0] mod3(input logic [5:0] t);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(t[1:0]) + 4'(t[3:2]) + 4'(t[5:4]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    return s2[1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cid_axis_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cid_axis_map
// Builds the interleave masks and bit offsets of every axis for one rank.
// ----------------------------------------------------------------------------
module cid_axis_map (
  input  logic [2:0]         dim_i,
  input  logic [5:0]         rank_i,
  output cid_pkg::axis_map_t map_o
);

  logic [cid_pkg::WORD_BITS-1:0] stride;
  logic [cid_pkg::WORD_BITS-1:0] below;
  logic [5:0]                    span [cid_pkg::AXES];
  logic [1:0]                    off  [cid_pkg::AXES];

  assign stride = cid_pkg::dilate({cid_pkg::WORD_BITS{1'b1}}, dim_i);
  assign below  = (cid_pkg::WORD_BITS'(1) << rank_i) - cid_pkg::WORD_BITS'(1);

  always_comb begin
    for (int j = 0; j < cid_pkg::AXES; j++) begin
      // Axis j owns bit b when (rank-1-b) mod d == j; its lowest bit sits at
      // (rank-1-j) mod d.
      span[j] = rank_i - 6'd1 - 6'(j);
      case (dim_i)
        3'd2:    off[j] = {1'b0, span[j][0]};
        3'd3:    off[j] = cid_pkg::mod3(span[j]);
        3'd4:    off[j] = span[j][1:0];
        default: off[j] = 2'd0;
      endcase
      map_o.off[j] = off[j];
      if ((3'(j) < dim_i) && (rank_i > 6'(j))) begin
        map_o.mask[j] = (stride << off[j]) & below;
      end else begin
        map_o.mask[j] = '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cid_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cid_datapath
// Single-pass operation logic: rank, split, build and masked field adds.
// ----------------------------------------------------------------------------
module cid_datapath #(
  parameter int ID_BITS    = 64,
  parameter int MAX_DIM    = 4,
  parameter int COORD_BITS = 32
) (
  input  logic [2:0]        dim_i,
  input  cid_pkg::cid_in_t  item_i,
  output cid_pkg::cid_out_t result_o
);

  localparam int W = cid_pkg::WORD_BITS;
  localparam logic [W-1:0] IdMask =
    (ID_BITS >= W) ? {W{1'b1}} : ((W'(1) << ID_BITS) - W'(1));
  localparam logic [W-1:0] CoordMask =
    (COORD_BITS >= W) ? {W{1'b1}} : ((W'(1) << COORD_BITS) - W'(1));
  localparam int         SignBit  = COORD_BITS - 1;
  localparam logic [5:0] MaxLevel = 6'(ID_BITS - 1);
  localparam logic [2:0] MaxDim   = 3'(MAX_DIM);

  logic [2:0]   dim;
  logic [W-1:0] cell_a;
  logic [W-1:0] cell_b;
  logic [5:0]   rank_a;
  logic [5:0]   rank_b;
  logic [5:0]   level_sat;
  logic [5:0]   map_rank;
  logic         is_shift1;
  cid_pkg::axis_map_t map;

  logic [cid_pkg::AXES-1:0][31:0]  coord_in;
  logic [cid_pkg::AXES-1:0][W-1:0] coord_sx;
  logic [cid_pkg::AXES-1:0][W-1:0] dep;
  logic [cid_pkg::AXES-1:0][W-1:0] addend;
  logic [cid_pkg::AXES-1:0][W-1:0] sum;
  logic [cid_pkg::AXES-1:0][W-1:0] gathered;
  logic [W-1:0] union_mask;
  logic [W-1:0] sum_all;
  logic [W-1:0] dep_all;
  logic [W-1:0] cell_res;

  always_comb begin
    if (dim_i == 3'd0) begin
      dim = 3'd1;
    end else if (dim_i > MaxDim) begin
      dim = MaxDim;
    end else begin
      dim = dim_i;
    end
  end

  assign cell_a    = item_i.cell_a & IdMask;
  assign cell_b    = item_i.cell_b & IdMask;
  assign rank_a    = cid_pkg::lead_one(cell_a);
  assign rank_b    = cid_pkg::lead_one(cell_b);
  assign level_sat = (item_i.level > MaxLevel) ? MaxLevel : item_i.level;
  assign map_rank  = (item_i.opcode == cid_pkg::OP_BUILD) ? level_sat : rank_a;
  assign is_shift1 = (item_i.opcode == cid_pkg::OP_AXIS_SHIFT);

  cid_axis_map u_axis_map (
    .dim_i  (dim),
    .rank_i (map_rank),
    .map_o  (map)
  );

  assign coord_in[0] = item_i.coord0;
  assign coord_in[1] = item_i.coord1;
  assign coord_in[2] = item_i.coord2;
  assign coord_in[3] = item_i.coord3;

  always_comb begin
    union_mask = '0;
    sum_all    = '0;
    dep_all    = '0;
    for (int j = 0; j < cid_pkg::AXES; j++) begin
      // A single-axis shift takes its delta from coord0 whatever the axis.
      coord_sx[j] = {32'd0, (is_shift1 ? coord_in[0] : coord_in[j])} & CoordMask;
      if (coord_sx[j][SignBit]) begin
        coord_sx[j] = coord_sx[j] | ~CoordMask;
      end
      dep[j] = (cid_pkg::dilate(coord_sx[j], dim) << map.off[j]) & map.mask[j];

      case (item_i.opcode)
        cid_pkg::OP_AXIS_SHIFT: addend[j] = (item_i.axis_sel == 2'(j)) ? dep[j] : '0;
        cid_pkg::OP_SHIFT_ALL:  addend[j] = dep[j];
        cid_pkg::OP_ADD_IDS:    addend[j] = cell_b & map.mask[j];
        default:                addend[j] = '0;
      endcase

      // Fill the gaps with ones so carries ripple across foreign bits.
      sum[j] = ((cell_a | ~map.mask[j]) + addend[j]) & map.mask[j];
      gathered[j] = cid_pkg::compact((cell_a & map.mask[j]) >> map.off[j], dim);

      union_mask = union_mask | map.mask[j];
      sum_all    = sum_all | sum[j];
      dep_all    = dep_all | dep[j];
    end
  end

  always_comb begin
    cell_res            = '0;
    result_o            = '0;
    result_o.rank_out   = rank_a;
    case (item_i.opcode)
      cid_pkg::OP_SPLIT: begin
        result_o.pos0 = gathered[0][cid_pkg::POS_BITS-1:0];
        result_o.pos1 = gathered[1][cid_pkg::POS_BITS-1:0];
        result_o.pos2 = gathered[2][cid_pkg::POS_BITS-1:0];
        result_o.pos3 = gathered[3][cid_pkg::POS_BITS-1:0];
      end
      cid_pkg::OP_BUILD: begin
        cell_res = (W'(1) << level_sat) | dep_all;
      end
      cid_pkg::OP_AXIS_SHIFT, cid_pkg::OP_SHIFT_ALL: begin
        cell_res = (cell_a & ~union_mask) | sum_all;
      end
      cid_pkg::OP_ADD_IDS: begin
        if (rank_b != rank_a) begin
          cell_res            = cell_a;
          result_o.rank_error = 1'b1;
        end else begin
          cell_res = (cell_a & ~union_mask) | sum_all;
        end
      end
      default: begin
        cell_res = '0;
      end
    endcase
    result_o.cell_out = cell_res & IdMask;
  end

endmodule
`default_nettype wire

// ===== rtl/dyadic_cell_id_arith_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dyadic_cell_id_arith_unit
// Cell-identifier arithmetic for a d-dimensional dyadic multigrid.
// ----------------------------------------------------------------------------
// Every transfer on the input channel yields exactly one result transfer.
// The item is captured in an input register, passes through the
// combinational logic (leading-one search, axis masks and four masked
// 64-bit adders) and lands in the result register, from which it is
// offered as the result, and the unit sustains one item per clock; only back
// pressure on the result channel slows it. The axis count is taken from a
// 3-bit register written through cfg_we_i/cfg_wdata_i (reset value 2; 0 acts
// as 1 and values above MAX_DIM act as MAX_DIM); write it only while idle.
module dyadic_cell_id_arith_unit #(
  parameter int ID_BITS    = 64,
  parameter int MAX_DIM    = 4,
  parameter int COORD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cid_pkg::cid_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cid_pkg::cid_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i
);

  logic              in_valid_d, in_valid_q;
  logic              out_valid_d, out_valid_q;
  logic [2:0]        dim_d, dim_q;
  cid_pkg::cid_in_t  in_q;
  cid_pkg::cid_out_t out_q;
  cid_pkg::cid_out_t result;
  logic              advance;
  logic              in_xfer;

  // The result register can take a new item when empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  cid_datapath #(
    .ID_BITS    (ID_BITS),
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .dim_i    (dim_q),
    .item_i   (in_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_valid_q && advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign dim_d = cfg_we_i ? cfg_wdata_i : dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dim_q       <= cid_pkg::DIM_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      dim_q       <= dim_d;
    end
  end

  // Payload registers: hold unless a transfer moves a new item in.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (in_valid_q && advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== tb/dyadic_cell_id_arith_unit_tb.sv =====
// ----------------------------------------------------------------------------
// dyadic_cell_id_arith_unit_tb
// Drives cell-id operations through the unit under every axis count and
// checks each result against an in-bench prediction, under random idling,
// one long result stall and a drain between every setting.
// ----------------------------------------------------------------------------
module dyadic_cell_id_arith_unit_tb;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int         LONG_STALL = 80;
  localparam int         PHASE_ITEMS = 170;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  cid_pkg::cid_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  cid_pkg::cid_out_t out_data_o;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_wdata_i = 3'd0;

  cid_pkg::cid_in_t  pending_items[$];
  cid_pkg::cid_out_t expected_results[$];
  cid_pkg::cid_out_t expected_now;
  logic [2:0]  dim_setting = cid_pkg::DIM_RESET;
  logic        in_taken = 1'b0;
  int unsigned idle_pct = 25;
  int unsigned stalls_asked = 0;
  int unsigned stalls_taken = 0;
  int unsigned stall_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned op_count[8];

  dyadic_cell_id_arith_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int cell_rank(input logic [63:0] x);
    int r;
    r = 0;
    while (x > 64'd1) begin
      x = x >> 1;
      r++;
    end
    return r;
  endfunction

  // Bits below the leading one that belong to axis j.
  function automatic logic [63:0] axis_bits(input int d, input int rank, input int j);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < rank; b++) begin
      if ((rank - 1 - b) % d == j) m[b] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [63:0] scatter(input logic [63:0] v, input logic [63:0] m);
    logic [63:0] r;
    int k;
    r = '0;
    k = 0;
    for (int b = 0; b < 64; b++) begin
      if (m[b]) begin
        r[b] = v[k];
        k++;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] gather(input logic [63:0] x, input logic [63:0] m);
    logic [63:0] r;
    int k;
    r = '0;
    k = 0;
    for (int b = 0; b < 64; b++) begin
      if (m[b]) begin
        r[k] = x[b];
        k++;
      end
    end
    return r;
  endfunction

  // Fill the holes outside the field with ones so the carry ripples through.
  function automatic logic [63:0] wrap_add(input logic [63:0] id, input logic [63:0] dd,
                                           input logic [63:0] m);
    logic [63:0] s;
    s = ((id | ~m) + (dd & m)) & m;
    return (id & ~m) | s;
  endfunction

  function automatic cid_pkg::cid_out_t predict_cell_op(input cid_pkg::cid_in_t it,
                                                        input logic [2:0] dim_raw);
    cid_pkg::cid_out_t res;
    int          d;
    int          ra;
    logic [63:0] m;
    logic [63:0] id_acc;
    logic [31:0] coord[4];
    logic [31:0] pos[4];
    res = '0;
    pos = '{default: '0};
    coord[0] = it.coord0;
    coord[1] = it.coord1;
    coord[2] = it.coord2;
    coord[3] = it.coord3;
    d = (dim_raw == 3'd0) ? 1 :
        ((int'(dim_raw) > cid_pkg::AXES) ? cid_pkg::AXES : int'(dim_raw));
    ra = cell_rank(it.cell_a);
    id_acc = '0;
    case (it.opcode)
      cid_pkg::OP_SPLIT: begin
        for (int j = 0; j < d; j++) pos[j] = 32'(gather(it.cell_a, axis_bits(d, ra, j)));
      end
      cid_pkg::OP_BUILD: begin
        id_acc = 64'd1 << it.level;
        for (int j = 0; j < d; j++)
          id_acc |= scatter({{32{coord[j][31]}}, coord[j]}, axis_bits(d, it.level, j));
      end
      cid_pkg::OP_AXIS_SHIFT: begin
        id_acc = it.cell_a;
        if (int'(it.axis_sel) < d) begin
          m = axis_bits(d, ra, it.axis_sel);
          id_acc = wrap_add(id_acc, scatter({{32{coord[0][31]}}, coord[0]}, m), m);
        end
      end
      cid_pkg::OP_SHIFT_ALL: begin
        id_acc = it.cell_a;
        for (int j = 0; j < d; j++) begin
          m = axis_bits(d, ra, j);
          id_acc = wrap_add(id_acc, scatter({{32{coord[j][31]}}, coord[j]}, m), m);
        end
      end
      cid_pkg::OP_ADD_IDS: begin
        id_acc = it.cell_a;
        if (cell_rank(it.cell_b) != ra) begin
          res.rank_error = 1'b1;
        end else begin
          for (int j = 0; j < d; j++) begin
            m = axis_bits(d, ra, j);
            id_acc = wrap_add(id_acc, it.cell_b & m, m);
          end
        end
      end
      default: begin
      end
    endcase
    res.cell_out = id_acc;
    res.rank_out = 6'(ra);
    res.pos0 = pos[0];
    res.pos1 = pos[1];
    res.pos2 = pos[2];
    res.pos3 = pos[3];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic cid_pkg::cid_in_t make_item(input logic [2:0] op, input logic [63:0] a,
                                                 input logic [63:0] b, input logic [5:0] lvl,
                                                 input logic [1:0] ax, input logic [31:0] c0,
                                                 input logic [31:0] c1, input logic [31:0] c2,
                                                 input logic [31:0] c3);
    cid_pkg::cid_in_t it;
    it.opcode = op;
    it.cell_a = a;
    it.cell_b = b;
    it.level = lvl;
    it.axis_sel = ax;
    it.coord0 = c0;
    it.coord1 = c1;
    it.coord2 = c2;
    it.coord3 = c3;
    return it;
  endfunction

  function automatic logic [63:0] cell_of_rank(input int r);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return (v & ((64'd1 << r) - 64'd1)) | (64'd1 << r);
  endfunction

  function automatic logic [63:0] random_cell();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      3: return cell_of_rank($urandom_range(7));
      default: return cell_of_rank($urandom_range(63));
    endcase
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'($urandom_range(7));
      4: return -32'($urandom_range(8, 1));
      default: return $urandom;
    endcase
  endfunction

  function automatic cid_pkg::cid_in_t random_item();
    cid_pkg::cid_in_t it;
    if ($urandom_range(19) == 0) it.opcode = 3'($urandom_range(OP_SPARE_7, OP_SPARE_6));
    else it.opcode = 3'($urandom_range(cid_pkg::OP_ADD_IDS));
    it.cell_a = random_cell();
    // Mostly give add ids a partner of equal rank so the sum path is exercised.
    if ($urandom_range(3) != 0) it.cell_b = cell_of_rank(cell_rank(it.cell_a));
    else it.cell_b = random_cell();
    it.level = 6'($urandom_range(63));
    it.axis_sel = 2'($urandom_range(3));
    it.coord0 = random_coord();
    it.coord1 = random_coord();
    it.coord2 = random_coord();
    it.coord3 = random_coord();
    return it;
  endfunction

  // Check at the rising edge, where the driver's updates have settled.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_dimension(input logic [2:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    dim_setting = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [2:0] dims[8];
    dims = '{3'd1, 3'd4, 3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners under the reset axis count of two.
    pending_items.push_back(make_item(cid_pkg::OP_RANK, '0, '0, '0, '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_RANK, 64'd1, '0, '0, '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_RANK, '1, '1, '1, '1, '1, '1, '1, '1));
    pending_items.push_back(make_item(cid_pkg::OP_SPLIT, '1, '0, '0, '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_SPLIT, 64'h8000_0000_0000_0000, '0, '0,
                                      '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_SPLIT, 64'h0000_0000_0000_002D, '0, '0,
                                      '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_BUILD, '0, '0, 6'd0, '0,
                                      '1, '1, '1, '1));
    pending_items.push_back(make_item(cid_pkg::OP_BUILD, '0, '0, 6'd63, '0,
                                      '1, '1, '1, '1));
    pending_items.push_back(make_item(cid_pkg::OP_BUILD, '0, '0, 6'd63, '0, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(make_item(cid_pkg::OP_BUILD, '0, '0, 6'd5, '0,
                                      32'd5, 32'd2, 32'd7, 32'd1));
    pending_items.push_back(make_item(cid_pkg::OP_AXIS_SHIFT, 64'h0000_0000_0000_01FF, '0,
                                      '0, 2'd0, 32'd1, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_AXIS_SHIFT, 64'h0000_0000_0000_0100, '0,
                                      '0, 2'd1, '1, '0, '0, '0));
    // Axes beyond the dimension leave the identifier alone.
    pending_items.push_back(make_item(cid_pkg::OP_AXIS_SHIFT, 64'h0000_0000_0000_0155, '0,
                                      '0, 2'd2, 32'd3, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_AXIS_SHIFT, '1, '0, '0, 2'd3,
                                      32'd1, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_SHIFT_ALL, '0, '0, '0, '0,
                                      32'd1, '1, 32'd1, '1));
    pending_items.push_back(make_item(cid_pkg::OP_SHIFT_ALL, 64'd1, '0, '0, '0,
                                      32'd5, 32'd5, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_SHIFT_ALL, '1, '0, '0, '0,
                                      32'd1, 32'd1, 32'd1, 32'd1));
    pending_items.push_back(make_item(cid_pkg::OP_ADD_IDS, 64'h0000_0000_0000_01FF,
                                      64'h0000_0000_0000_0101, '0, '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_ADD_IDS, 64'h0000_0000_0000_01FF,
                                      64'h0000_0000_0000_0080, '0, '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_ADD_IDS, '0, '0, '0, '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(cid_pkg::OP_ADD_IDS, '1, '1, '0, '0, '0, '0, '0, '0));
    pending_items.push_back(make_item(OP_SPARE_6, '1, '1, '1, '1, '1, '1, '1, '1));
    pending_items.push_back(make_item(OP_SPARE_7, '1, '1, '1, '1, '1, '1, '1, '1));
    repeat (PHASE_ITEMS) pending_items.push_back(random_item());
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_dimension(dims[p]);
      // One phase stalls the result side hard while items keep coming; the
      // next runs both sides flat out.
      if (p == 1) stalls_asked = stalls_asked + 1;
      idle_pct = (p == 2) ? 0 : 25;
      repeat (PHASE_ITEMS) pending_items.push_back(random_item());
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    $display("Sent %0d transfers, checked %0d results, axis counts 0 to 7 incl. a %0d-cycle stall",
             items_sent, results_seen, LONG_STALL);
    $display("Per opcode: rank %0d split %0d build %0d axis %0d all %0d add %0d spare %0d",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4], op_count[5],
             op_count[6] + op_count[7]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // Hold the payload until the transfer, then load the next item or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stalls_taken != stalls_asked) begin
      stalls_taken <= stalls_taken + 1;
      stall_left <= LONG_STALL;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_cell_op(in_data_i, dim_setting));
        items_sent++;
        op_count[in_data_i.opcode]++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: unexpected transfer, cell %h", results_seen,
                     out_data_o.cell_out);
        end else begin
          expected_now = expected_results.pop_front();
          check_field("cell_out", expected_now.cell_out, out_data_o.cell_out);
          check_field("rank_out", 64'(expected_now.rank_out), 64'(out_data_o.rank_out));
          check_field("pos0", 64'(expected_now.pos0), 64'(out_data_o.pos0));
          check_field("pos1", 64'(expected_now.pos1), 64'(out_data_o.pos1));
          check_field("pos2", 64'(expected_now.pos2), 64'(out_data_o.pos2));
          check_field("pos3", 64'(expected_now.pos3), 64'(out_data_o.pos3));
          check_field("rank_error", 64'(expected_now.rank_error),
                      64'(out_data_o.rank_error));
        end
      end
    end
  end

endmodule
